@@ hdl/swsr_pkg.sv @@
// shared types and constants for the sliding window scalar recoder
// no dependencies; imported by every module of the block
package swsr_pkg;

  localparam int BYTE_W       = 8;
  localparam int DIGIT_W      = 5;
  localparam int BASE_W       = 8;
  localparam int SHOWN_DIGITS = 4;
  localparam int WINDOW_AHEAD = 6;
  localparam int DIGIT_MAX    = 15;
  localparam int QUEUE_DEPTH  = 4;

  typedef logic signed [DIGIT_W-1:0] digit_t;

  // one classified input item on its way to the recoder
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              keep;
    logic              last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

@@ hdl/swsr_queue.sv @@
// short fifo between the byte front end and the recoder
// depends on swsr_pkg for the entry and status types
module swsr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  swsr_pkg::q_entry_t   push_data,
  input  logic                 pop,
  output swsr_pkg::q_entry_t   pop_data,
  output swsr_pkg::q_status_t  status
);
  import swsr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_entry_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 do_push, do_pop;

  assign status.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign pop_data     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/swsr_front.sv @@
// input front end: accepts scalar bytes and marks surplus ones
// depends on swsr_pkg; feeds swsr_queue
module swsr_front #(
  parameter int SCALAR_BITS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [swsr_pkg::BYTE_W-1:0]        in_scalar_byte,
  input  logic                               in_byte_last,
  input  swsr_pkg::q_status_t                q_stat,
  output logic                               q_push,
  output swsr_pkg::q_entry_t                 q_data
);
  import swsr_pkg::*;

  localparam int BYTE_SLOTS = (SCALAR_BITS + 7) / 8;
  localparam int FW         = $clog2(BYTE_SLOTS + 1);

  logic [FW-1:0] cnt_r, cnt_nxt;
  logic          keep;

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full;
  assign keep     = (cnt_r < FW'(BYTE_SLOTS));

  assign q_data.data = in_scalar_byte;
  assign q_data.keep = keep;
  assign q_data.last = in_byte_last;

  always_comb begin
    cnt_nxt = cnt_r;
    if (q_push) begin
      if (in_byte_last) begin
        cnt_nxt = '0;
      end else if (keep) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ hdl/swsr_back.sv @@
// recoder back end: byte store, width-5 signed window walk, result grouping
// depends on swsr_pkg; pops items from swsr_queue
module swsr_back #(
  parameter int SCALAR_BITS       = 256,
  parameter int DIGITS_PER_RESULT = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  swsr_pkg::q_status_t                q_stat,
  input  swsr_pkg::q_entry_t                 q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [swsr_pkg::BASE_W-1:0]        out_digit_base,
  output logic signed [swsr_pkg::DIGIT_W-1:0] out_digit_a,
  output logic signed [swsr_pkg::DIGIT_W-1:0] out_digit_b,
  output logic signed [swsr_pkg::DIGIT_W-1:0] out_digit_c,
  output logic signed [swsr_pkg::DIGIT_W-1:0] out_digit_d,
  output logic                               out_run_last
);
  import swsr_pkg::*;

  localparam int BYTE_SLOTS = (SCALAR_BITS + 7) / 8;
  localparam int FW         = $clog2(BYTE_SLOTS + 1);
  localparam int IW         = $clog2(SCALAR_BITS);
  localparam int PW         = $clog2(SCALAR_BITS + WINDOW_AHEAD + 2);
  localparam int GW         = $clog2(DIGITS_PER_RESULT + 1);
  localparam int ACC_W      = 8;
  localparam int WIN_W      = WINDOW_AHEAD + 1;

  localparam logic signed [ACC_W-1:0] AccMax = ACC_W'(DIGIT_MAX);
  localparam logic signed [ACC_W-1:0] AccMin = -ACC_W'(DIGIT_MAX);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_PAD   = 4'b0010,
    ST_PRIME = 4'b0100,
    ST_RUN   = 4'b1000
  } state_t;

  typedef struct packed {
    digit_t           d;
    logic [WIN_W-1:0] w;
    logic             c;
  } step_t;

  // one bit position: look ahead up to six places, absorb or subtract with carry
  function automatic step_t recode_pos(input logic [WIN_W-1:0] win, input logic cin,
                                       input logic [WIN_W:0] alive);
    step_t                    r;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  hi;
    logic                     stop;
    logic                     go;
    r.w  = win;
    r.c  = cin;
    acc  = '0;
    hi   = '0;
    stop = 1'b0;
    go   = 1'b0;
    if (win[0]) begin
      acc = ACC_W'(1);
      for (int b = 1; b <= WINDOW_AHEAD; b++) begin
        if (!stop) begin
          if (!alive[b]) begin
            stop = 1'b1;
          end else if (r.w[b]) begin
            hi = ACC_W'(1) <<< b;
            if (acc + hi <= AccMax) begin
              acc    = acc + hi;
              r.w[b] = 1'b0;
            end else if (acc - hi >= AccMin) begin
              acc = acc - hi;
              go  = 1'b1;
              // ripple the carry upward, stopping past the top digit
              for (int k = 1; k <= WINDOW_AHEAD; k++) begin
                if (go && k >= b) begin
                  if (!alive[k]) begin
                    go = 1'b0;
                  end else if (!r.w[k]) begin
                    r.w[k] = 1'b1;
                    go     = 1'b0;
                  end else begin
                    r.w[k] = 1'b0;
                  end
                end
              end
              if (go && alive[WIN_W]) begin
                r.c = 1'b1;
              end
              go = 1'b0;
            end else begin
              stop = 1'b1;
            end
          end
        end
      end
    end
    r.d = acc[DIGIT_W-1:0];
    return r;
  endfunction

  state_t               state_r, state_nxt;
  logic [FW-1:0]        fill_r, fill_nxt;
  logic [BYTE_W-1:0]    line_r [BYTE_SLOTS];
  logic [BYTE_W-1:0]    line_nxt [BYTE_SLOTS];
  logic [2:0]           bit_ptr_r, bit_ptr_nxt;
  logic [2:0]           prime_r, prime_nxt;
  logic [WIN_W-1:0]     win_r, win_nxt;
  logic                 cy_r, cy_nxt;
  logic [IW-1:0]        pos_r, pos_nxt;
  logic [GW-1:0]        gidx_r, gidx_nxt;
  digit_t               grp_r [SHOWN_DIGITS];
  digit_t               grp_nxt [SHOWN_DIGITS];
  digit_t               grp_cur [SHOWN_DIGITS];
  logic [BASE_W-1:0]    base_r, base_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [BASE_W-1:0]    out_base_r, out_base_nxt;
  digit_t               out_dig_r [SHOWN_DIGITS];
  digit_t               out_dig_nxt [SHOWN_DIGITS];
  logic                 out_last_r, out_last_nxt;

  logic                 feed;
  logic                 feed_adv;
  logic                 line_shift;
  logic [BYTE_W-1:0]    line_in;
  logic [WIN_W:0]       alive;
  step_t                step;
  logic                 last_pos;
  logic                 grp_done;
  logic                 can_emit;
  logic                 step_ok;

  assign feed     = line_r[0][bit_ptr_r];
  assign last_pos = (pos_r == IW'(SCALAR_BITS - 1));
  assign grp_done = (gidx_r == GW'(DIGITS_PER_RESULT - 1)) || last_pos;
  assign can_emit = !out_valid_r || !out_stall;
  assign step_ok  = !grp_done || can_emit;

  always_comb begin
    for (int j = 0; j <= WIN_W; j++) begin
      alive[j] = (PW'(pos_r) + PW'(j)) < PW'(SCALAR_BITS);
    end
  end

  assign step = recode_pos(win_r, cy_r, alive);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    bit_ptr_nxt   = bit_ptr_r;
    prime_nxt     = prime_r;
    win_nxt       = win_r;
    cy_nxt        = cy_r;
    pos_nxt       = pos_r;
    gidx_nxt      = gidx_r;
    base_nxt      = base_r;
    grp_nxt       = grp_r;
    grp_cur       = grp_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_base_nxt  = out_base_r;
    out_dig_nxt   = out_dig_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    feed_adv      = 1'b0;
    line_shift    = 1'b0;
    line_in       = '0;

    for (int j = 0; j < SHOWN_DIGITS; j++) begin
      if (int'(gidx_r) == j) begin
        grp_cur[j] = step.d;
      end
    end

    case (state_r)
      ST_LOAD: begin
        q_pop = !q_stat.empty;
        if (q_pop) begin
          if (q_data.keep && fill_r < FW'(BYTE_SLOTS)) begin
            line_shift = 1'b1;
            line_in    = q_data.data;
            fill_nxt   = fill_r + 1'b1;
          end
          if (q_data.last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // slide the loaded bytes down so the first one sits at the bottom
        if (fill_r == FW'(BYTE_SLOTS)) begin
          state_nxt   = ST_PRIME;
          bit_ptr_nxt = '0;
          prime_nxt   = '0;
          win_nxt     = '0;
          cy_nxt      = 1'b0;
        end else begin
          line_shift = 1'b1;
          fill_nxt   = fill_r + 1'b1;
        end
      end
      ST_PRIME: begin
        feed_adv  = 1'b1;
        win_nxt   = {feed, win_r[WIN_W-1:1]};
        prime_nxt = prime_r + 1'b1;
        if (prime_r == 3'(WINDOW_AHEAD)) begin
          state_nxt = ST_RUN;
          pos_nxt   = '0;
          gidx_nxt  = '0;
          base_nxt  = '0;
          for (int j = 0; j < SHOWN_DIGITS; j++) begin
            grp_nxt[j] = '0;
          end
        end
      end
      ST_RUN: begin
        if (step_ok) begin
          feed_adv = 1'b1;
          // the pending carry lands on the bit entering the window
          win_nxt  = {feed ^ step.c, step.w[WIN_W-1:1]};
          cy_nxt   = feed & step.c;
          pos_nxt  = pos_r + 1'b1;
          if (grp_done) begin
            out_valid_nxt = 1'b1;
            out_base_nxt  = base_r;
            out_dig_nxt   = grp_cur;
            out_last_nxt  = last_pos;
            gidx_nxt      = '0;
            base_nxt      = base_r + BASE_W'(DIGITS_PER_RESULT);
            for (int j = 0; j < SHOWN_DIGITS; j++) begin
              grp_nxt[j] = '0;
            end
          end else begin
            gidx_nxt = gidx_r + 1'b1;
            grp_nxt  = grp_cur;
          end
          if (last_pos) begin
            state_nxt = ST_LOAD;
            fill_nxt  = '0;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    if (feed_adv) begin
      bit_ptr_nxt = bit_ptr_r + 1'b1;
      if (bit_ptr_r == 3'd7) begin
        line_shift = 1'b1;
      end
    end

    for (int k = 0; k < BYTE_SLOTS; k++) begin
      line_nxt[k] = line_r[k];
    end
    if (line_shift) begin
      for (int k = 0; k < BYTE_SLOTS - 1; k++) begin
        line_nxt[k] = line_r[k + 1];
      end
      line_nxt[BYTE_SLOTS - 1] = line_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      fill_r      <= '0;
      bit_ptr_r   <= '0;
      prime_r     <= '0;
      cy_r        <= 1'b0;
      pos_r       <= '0;
      gidx_r      <= '0;
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bit_ptr_r   <= bit_ptr_nxt;
      prime_r     <= prime_nxt;
      cy_r        <= cy_nxt;
      pos_r       <= pos_nxt;
      gidx_r      <= gidx_nxt;
      base_r      <= base_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    line_r     <= line_nxt;
    win_r      <= win_nxt;
    grp_r      <= grp_nxt;
    out_base_r <= out_base_nxt;
    out_dig_r  <= out_dig_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_base = out_base_r;
  assign out_digit_a    = out_dig_r[0];
  assign out_digit_b    = out_dig_r[1];
  assign out_digit_c    = out_dig_r[2];
  assign out_digit_d    = out_dig_r[3];
  assign out_run_last   = out_last_r;

endmodule

@@ hdl/sliding_window_scalar_recoder_core.sv @@
// Signed sliding-window (width 5) scalar recoder, top level.
// Input channel: one scalar byte per item, least significant byte first;
//   in_byte_last marks the final byte and starts recoding. Bytes past
//   SCALAR_BITS/8 are dropped (their last mark still counts), missing bytes
//   read as zero.
// Result channel: ceil(SCALAR_BITS/DIGITS_PER_RESULT) items per scalar, each
//   with the base bit position and four signed odd-or-zero digits, lowest
//   first; out_run_last flags the final one.
// Timing: the front end takes one item per cycle while its four-entry queue
//   has room. The recoder drains the queue one byte per cycle, then aligns
//   the byte store, fills its look-ahead window and walks the bit positions,
//   one per cycle while no finished group waits on a stalled result. Results
//   leave during that walk. The recoder takes bytes of the next scalar only
//   after the walk ends; meanwhile the front end fills the queue.
// A stalled result holds in the output register; the walk pauses only when a
//   finished group finds that register still occupied.
// Reset (rst_n low, synchronous) empties the queue, clears the byte count
//   and drops any result not yet taken.
module sliding_window_scalar_recoder_core #(
  parameter int SCALAR_BITS       = 256,
  parameter int DIGITS_PER_RESULT = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [swsr_pkg::BYTE_W-1:0]          in_scalar_byte,
  input  logic                                 in_byte_last,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [swsr_pkg::BASE_W-1:0]          out_digit_base,
  output logic signed [swsr_pkg::DIGIT_W-1:0]  out_digit_a,
  output logic signed [swsr_pkg::DIGIT_W-1:0]  out_digit_b,
  output logic signed [swsr_pkg::DIGIT_W-1:0]  out_digit_c,
  output logic signed [swsr_pkg::DIGIT_W-1:0]  out_digit_d,
  output logic                                 out_run_last
);
  import swsr_pkg::*;

  q_status_t q_stat;
  q_entry_t  q_in;
  q_entry_t  q_out;
  logic      q_push;
  logic      q_pop;

  swsr_front #(
    .SCALAR_BITS (SCALAR_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_scalar_byte (in_scalar_byte),
    .in_byte_last   (in_byte_last),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  swsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .status    (q_stat)
  );

  swsr_back #(
    .SCALAR_BITS       (SCALAR_BITS),
    .DIGITS_PER_RESULT (DIGITS_PER_RESULT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_base (out_digit_base),
    .out_digit_a    (out_digit_a),
    .out_digit_b    (out_digit_b),
    .out_digit_c    (out_digit_c),
    .out_digit_d    (out_digit_d),
    .out_run_last   (out_run_last)
  );

endmodule

@@ hdl/swsr_checker.sv @@
// port-level checks for the sliding window scalar recoder
// depends on swsr_pkg; bound to sliding_window_scalar_recoder_core below
module swsr_checker #(
  parameter int SCALAR_BITS       = 256,
  parameter int DIGITS_PER_RESULT = 4
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [swsr_pkg::BYTE_W-1:0]          in_scalar_byte,
  input logic                                 in_byte_last,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [swsr_pkg::BASE_W-1:0]          out_digit_base,
  input logic signed [swsr_pkg::DIGIT_W-1:0]  out_digit_a,
  input logic signed [swsr_pkg::DIGIT_W-1:0]  out_digit_b,
  input logic signed [swsr_pkg::DIGIT_W-1:0]  out_digit_c,
  input logic signed [swsr_pkg::DIGIT_W-1:0]  out_digit_d,
  input logic                                 out_run_last
);
  import swsr_pkg::*;

  localparam int NUM_RESULTS = (SCALAR_BITS + DIGITS_PER_RESULT - 1) / DIGITS_PER_RESULT;
  localparam int LAST_BASE   = ((NUM_RESULTS - 1) * DIGITS_PER_RESULT) % 256;

  // a stalled input item stays offered unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_scalar_byte) && $stable(in_byte_last))
    else $error("stalled input item changed");

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_digit_base) && $stable(out_digit_a)
      && $stable(out_digit_b) && $stable(out_digit_c)
      && $stable(out_digit_d) && $stable(out_run_last))
    else $error("stalled result changed");

  // the closing result of a scalar always covers the top group
  a_last_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_last |-> out_digit_base == BASE_W'(LAST_BASE))
    else $error("final result at wrong base");

  // every recoded digit is zero or odd
  a_digit_odd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_a == '0 || out_digit_a[0]) && (out_digit_b == '0 || out_digit_b[0])
      && (out_digit_c == '0 || out_digit_c[0]) && (out_digit_d == '0 || out_digit_d[0]))
    else $error("even nonzero digit");

endmodule

bind sliding_window_scalar_recoder_core swsr_checker #(
  .SCALAR_BITS       (SCALAR_BITS),
  .DIGITS_PER_RESULT (DIGITS_PER_RESULT)
) u_swsr_checker (.*);

@@ bench/swsr_recode_checker.sv @@
// checker for the sliding window scalar recoder: predicts the signed digit groups
// from the accepted bytes and compares every accepted result item in order
// depends on swsr_pkg for the digit type and the window constants
`timescale 1ns / 100ps

module swsr_recode_checker #(
  parameter int SCALAR_BITS       = 256,
  parameter int DIGITS_PER_RESULT = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [swsr_pkg::BYTE_W-1:0]  in_scalar_byte,
  input  logic                         in_byte_last,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [swsr_pkg::BASE_W-1:0]  out_digit_base,
  input  swsr_pkg::digit_t             out_digit_a,
  input  swsr_pkg::digit_t             out_digit_b,
  input  swsr_pkg::digit_t             out_digit_c,
  input  swsr_pkg::digit_t             out_digit_d,
  input  logic                         out_run_last,
  output int                           fail_count,
  output int                           pending_groups,
  output int                           groups_checked,
  output int                           scalars_recoded
);
  import swsr_pkg::*;

  localparam int BYTE_SLOTS  = (SCALAR_BITS + 7) / 8;
  localparam int GROUP_COUNT = (SCALAR_BITS + DIGITS_PER_RESULT - 1) / DIGITS_PER_RESULT;
  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic [BASE_W-1:0]             base;
    digit_t [SHOWN_DIGITS-1:0]     digit;
    logic                          run_last;
  } digit_group_t;

  int           bit_digits [SCALAR_BITS];
  int           bytes_stored;
  digit_group_t expected_groups [$];

  initial begin
    fail_count      = 0;
    pending_groups  = 0;
    groups_checked  = 0;
    scalars_recoded = 0;
    bytes_stored    = 0;
    foreach (bit_digits[i]) bit_digits[i] = 0;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    if (fail_count < MAX_REPORTS) begin
      $display("%0t: mismatch on %s after %0d groups: got %0d, want %0d",
               $realtime, what, groups_checked, got, want);
    end
    fail_count++;
  endtask

  task automatic store_byte(input logic [BYTE_W-1:0] value);
    int pos;
    if (bytes_stored < BYTE_SLOTS) begin
      for (int j = 0; j < 8; j++) begin
        pos = bytes_stored * 8 + j;
        if (pos < SCALAR_BITS) bit_digits[pos] = int'(value[j]);
      end
      bytes_stored++;
    end
  endtask

  // width-5 signed window, rewriting the bit digits in place from the bottom
  task automatic recode_store();
    int hi;
    for (int i = 0; i < SCALAR_BITS; i++) begin
      if (bit_digits[i] == 0) continue;
      for (int b = 1; b <= WINDOW_AHEAD && i + b < SCALAR_BITS; b++) begin
        if (bit_digits[i + b] == 0) continue;
        hi = bit_digits[i + b] * (1 << b);
        if (bit_digits[i] + hi <= DIGIT_MAX) begin
          bit_digits[i] += hi;
          bit_digits[i + b] = 0;
        end else if (bit_digits[i] - hi >= -DIGIT_MAX) begin
          bit_digits[i] -= hi;
          // carry ripples up, anything past the top bit is lost
          for (int k = i + b; k < SCALAR_BITS; k++) begin
            if (bit_digits[k] == 0) begin
              bit_digits[k] = 1;
              break;
            end
            bit_digits[k] = 0;
          end
        end else begin
          break;
        end
      end
    end
  endtask

  task automatic queue_groups();
    digit_group_t grp;
    int           pos;
    for (int r = 0; r < GROUP_COUNT; r++) begin
      grp.base = BASE_W'(r * DIGITS_PER_RESULT);
      for (int j = 0; j < SHOWN_DIGITS; j++) begin
        pos = r * DIGITS_PER_RESULT + j;
        if (j < DIGITS_PER_RESULT && pos < SCALAR_BITS) grp.digit[j] = digit_t'(bit_digits[pos]);
        else grp.digit[j] = '0;
      end
      grp.run_last = (r == GROUP_COUNT - 1);
      expected_groups.push_back(grp);
    end
    foreach (bit_digits[i]) bit_digits[i] = 0;
    bytes_stored = 0;
  endtask

  task automatic check_group();
    digit_group_t want;
    digit_t       got [SHOWN_DIGITS];
    got = '{out_digit_a, out_digit_b, out_digit_c, out_digit_d};
    if (expected_groups.size() == 0) begin
      report_mismatch("unexpected item at digit_base", int'(out_digit_base), -1);
    end else begin
      want = expected_groups.pop_front();
      if (out_digit_base !== want.base)
        report_mismatch("digit_base", int'(out_digit_base), int'(want.base));
      for (int j = 0; j < SHOWN_DIGITS; j++) begin
        if (got[j] !== want.digit[j])
          report_mismatch($sformatf("digit %0d of base %0d", j, want.base),
                          int'(got[j]), int'(want.digit[j]));
      end
      if (out_run_last !== want.run_last)
        report_mismatch("run_last", int'(out_run_last), int'(want.run_last));
    end
    groups_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (bit_digits[i]) bit_digits[i] = 0;
      bytes_stored = 0;
      expected_groups.delete();
    end else begin
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        store_byte(in_scalar_byte);
        if (in_byte_last) begin
          recode_store();
          queue_groups();
          scalars_recoded++;
        end
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) check_group();
    end
    pending_groups = expected_groups.size();
  end

endmodule

@@ bench/tb_sliding_window_scalar_recoder_core.sv @@
// top of the recoder testbench: clock, reset, byte stimulus and result stall
// depends on swsr_pkg, sliding_window_scalar_recoder_core and swsr_recode_checker
`timescale 1ns / 100ps

module tb_sliding_window_scalar_recoder_core;
  import swsr_pkg::*;

  localparam int SCALAR_BITS       = 256;
  localparam int DIGITS_PER_RESULT = 4;
  localparam int ITEM_TARGET       = 240;
  localparam int NO_IDLE_FROM      = 190;
  localparam int LONG_HOLD         = 400;
  localparam int DRAIN_CYCLES      = 400;
  localparam int CYCLE_LIMIT       = 400000;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZERO, FILL_SPARSE, FILL_DENSE} fill_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [BYTE_W-1:0] in_scalar_byte;
  logic              in_byte_last;
  logic              out_valid;
  logic              out_stall;
  logic [BASE_W-1:0] out_digit_base;
  digit_t            out_digit_a;
  digit_t            out_digit_b;
  digit_t            out_digit_c;
  digit_t            out_digit_d;
  logic              out_run_last;

  int   fail_count;
  int   pending_groups;
  int   groups_checked;
  int   scalars_recoded;
  int   items_sent = 0;
  int   cycle_count = 0;
  logic no_idle = 1'b0;
  logic hold_output = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sliding_window_scalar_recoder_core #(
    .SCALAR_BITS      (SCALAR_BITS),
    .DIGITS_PER_RESULT(DIGITS_PER_RESULT)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_scalar_byte(in_scalar_byte),
    .in_byte_last  (in_byte_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_digit_base(out_digit_base),
    .out_digit_a   (out_digit_a),
    .out_digit_b   (out_digit_b),
    .out_digit_c   (out_digit_c),
    .out_digit_d   (out_digit_d),
    .out_run_last  (out_run_last)
  );

  swsr_recode_checker #(
    .SCALAR_BITS      (SCALAR_BITS),
    .DIGITS_PER_RESULT(DIGITS_PER_RESULT)
  ) CHECK (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_scalar_byte (in_scalar_byte),
    .in_byte_last   (in_byte_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_base (out_digit_base),
    .out_digit_a    (out_digit_a),
    .out_digit_b    (out_digit_b),
    .out_digit_c    (out_digit_c),
    .out_digit_d    (out_digit_d),
    .out_run_last   (out_run_last),
    .fail_count     (fail_count),
    .pending_groups (pending_groups),
    .groups_checked (groups_checked),
    .scalars_recoded(scalars_recoded)
  );

  // offer one item and return at the edge that takes it
  task automatic offer_byte(input logic [BYTE_W-1:0] value, input logic last);
    int gap;
    @(negedge clk);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_scalar_byte <= value;
    in_byte_last   <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    items_sent++;
  endtask

  task automatic send_scalar(input int n_bytes, input fill_t fill);
    logic [BYTE_W-1:0] value;
    for (int idx = 0; idx < n_bytes; idx++) begin
      case (fill)
        FILL_ONES:   value = '1;
        FILL_ZERO:   value = '0;
        FILL_SPARSE: value = ($urandom_range(0, 1) == 0) ? '0 : BYTE_W'(1 << $urandom_range(0, 7));
        FILL_DENSE:  value = ~BYTE_W'(1 << $urandom_range(0, 7));
        default:     value = BYTE_W'($urandom);
      endcase
      offer_byte(value, idx == n_bytes - 1);
    end
  endtask

  // result side: random stall bursts, one long hold on request, none at the end
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_output) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        hold_output = 1'b0;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    int    scalar_idx;
    int    pick;
    int    n_bytes;
    fill_t fill;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_scalar_byte = '0;
    in_byte_last   = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short scalars, the rest of the store reads as zero
    offer_byte(8'h00, 1'b1);
    offer_byte(8'hFF, 1'b1);
    offer_byte(8'h01, 1'b1);
    offer_byte(8'h80, 1'b1);
    offer_byte(8'hAA, 1'b0);
    offer_byte(8'h55, 1'b1);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'hFF, 1'b0);
    offer_byte(8'hFF, 1'b1);
    offer_byte(8'h0F, 1'b0);
    offer_byte(8'hF0, 1'b1);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'h00, 1'b0);
    offer_byte(8'h81, 1'b1);
    offer_byte(8'h13, 1'b0);
    offer_byte(8'hEB, 1'b1);

    scalar_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= NO_IDLE_FROM) no_idle = 1'b1;
      case (scalar_idx)
        0: send_scalar(32, FILL_ONES);     // carry runs off the top bit
        1: send_scalar(36, FILL_RANDOM);   // surplus bytes, mark on a dropped byte
        2: begin
          // output held while the next scalars queue up behind it
          hold_output = 1'b1;
          send_scalar(32, FILL_RANDOM);
        end
        default: begin
          pick = $urandom_range(0, 9);
          if (pick < 6) n_bytes = 32;
          else if (pick < 8) n_bytes = $urandom_range(1, 31);
          else n_bytes = $urandom_range(33, 40);
          fill = fill_t'($urandom_range(0, 4));
          send_scalar(n_bytes, fill);
        end
      endcase
      scalar_idx++;
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (pending_groups != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes sent, %0d scalars recoded, %0d digit groups compared",
             items_sent, scalars_recoded, groups_checked);
    $display("covered short, full, surplus and all-ones scalars plus a long output hold");
    if (fail_count == 0 && pending_groups == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/swsr_pkg.sv
hdl/swsr_queue.sv
hdl/swsr_front.sv
hdl/swsr_back.sv
hdl/sliding_window_scalar_recoder_core.sv
hdl/swsr_checker.sv
bench/swsr_recode_checker.sv
bench/tb_sliding_window_scalar_recoder_core.sv
